// ----- src/dvrt_pkg.sv -----
// Package for the distance-vector route table.
// Holds the slot record type, the controller state type and the fixed codes and limits.
// No dependencies.
package dvrt_pkg;

    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] loc;
        logic [7:0] nhop;
        logic [4:0] cost;
        logic [7:0] age;
        logic       changed;
    } t_slot;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_ADV     = 8'b0000_0010,
        S_ADV_END = 8'b0000_0100,
        S_LOOK    = 8'b0000_1000,
        S_CNT     = 8'b0001_0000,
        S_DUMP    = 8'b0010_0000,
        S_TICK    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    localparam logic [2:0] ACT_ADVERT = 3'd0;
    localparam logic [2:0] ACT_NBREQ  = 3'd1;
    localparam logic [2:0] ACT_LOOKUP = 3'd2;
    localparam logic [2:0] ACT_DUMP   = 3'd3;
    localparam logic [2:0] ACT_TICK   = 3'd4;

    localparam logic [1:0] CFG_OWN_ADDR   = 2'd0;
    localparam logic [1:0] CFG_INVALID    = 2'd1;
    localparam logic [1:0] CFG_FLUSH      = 2'd2;

    localparam logic [7:0] RST_OWN_ADDR   = 8'd0;
    localparam logic [7:0] RST_INVALID    = 8'd180;
    localparam logic [7:0] RST_FLUSH      = 8'd240;

    localparam logic [4:0] COST_LOCAL   = 5'd31;
    localparam logic [4:0] COST_UNREACH = 5'd16;
    localparam logic [7:0] AGE_MAX      = 8'd255;

    localparam int         MAX_OUT = 32;
    localparam int         RECW    = 6;

endpackage

// ----- src/dvrt_slot_ram.sv -----
// Single-port-write, single-port-read slot memory with a registered read.
// Depends on dvrt_pkg for the slot record type.
module dvrt_slot_ram
    import dvrt_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot         o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot         i_wr_data
);

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/distance_vector_route_table.sv -----
// Top level of the distance-vector route table.
// Depends on dvrt_pkg and dvrt_slot_ram.
//
// Channel   Direction  Handshake                    Payload
// input     in         start & !busy                i_action .. i_adv_cost
// result    out        o_result_valid, one cycle    o_entry_valid .. o_last
// config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// Every action walks the slot memory one entry per cycle through its registered read port.
// A neighbor request adds a second walk, a changed dump is a count walk plus an emit walk.
// Reset clears the valid bits and the control state; the memory needs no clearing pass.
// Results cannot be stalled by the receiver; busy is low again when the last result shows.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_action,
    input  logic [7:0] i_local_addr,
    input  logic [7:0] i_neighbor_addr,
    input  logic [7:0] i_dest_addr,
    input  logic [4:0] i_adv_cost,
    output logic       o_result_valid,
    output logic       o_entry_valid,
    output logic [7:0] o_route_dest,
    output logic [4:0] o_route_cost,
    output logic [7:0] o_route_local,
    output logic [7:0] o_route_next,
    output logic       o_status,
    output logic       o_changes_pending,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int IW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES);

    t_state                   r_state, n_state;
    logic [IW-1:0]            r_ridx, n_ridx;
    logic                     r_evalid, n_evalid;
    logic [AW-1:0]            r_eidx;
    logic [TABLE_ENTRIES-1:0] r_used, n_used;
    logic                     r_pend, n_pend;
    logic                     r_nbmode, n_nbmode;
    logic                     r_look, n_look;
    logic [7:0]               r_loc, n_loc;
    logic [7:0]               r_nb, n_nb;
    logic [7:0]               r_dest, n_dest;
    logic [4:0]               r_cost, n_cost;
    logic                     r_hit, n_hit;
    logic [AW-1:0]            r_fresh, n_fresh;
    logic                     r_fresh_ok, n_fresh_ok;
    logic                     r_drop, n_drop;
    logic [IW-1:0]            r_cnt, n_cnt;
    logic [RECW-1:0]          r_nrec, n_nrec;
    logic                     r_hold_v, n_hold_v;
    t_slot                    r_hold, n_hold;
    logic [7:0]               r_own, r_inv, r_flush;

    logic                     r_o_valid, r_o_ev, r_o_status, r_o_pend, r_o_last;
    logic [7:0]               r_o_dest, r_o_loc, r_o_next;
    logic [4:0]               r_o_cost;

    t_slot                    rd_data, wr_data, mod;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     issue, scan_done, stop, used_e, mk;
    logic                     emit, emit_ev, emit_last;
    t_slot                    emit_rec;
    logic [5:0]               inc;
    logic [7:0]               age1;

    dvrt_slot_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (r_ridx[AW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign inc    = {1'b0, r_cost} + 6'd1;
    assign used_e = r_used[r_eidx];

    always_comb begin
        n_state    = r_state;
        n_ridx     = r_ridx;
        n_used     = r_used;
        n_pend     = r_pend;
        n_nbmode   = r_nbmode;
        n_look     = r_look;
        n_loc      = r_loc;
        n_nb       = r_nb;
        n_dest     = r_dest;
        n_cost     = r_cost;
        n_hit      = r_hit;
        n_fresh    = r_fresh;
        n_fresh_ok = r_fresh_ok;
        n_drop     = r_drop;
        n_cnt      = r_cnt;
        n_nrec     = r_nrec;
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        wr_en      = 1'b0;
        wr_addr    = r_eidx;
        wr_data    = rd_data;
        stop       = 1'b0;
        emit       = 1'b0;
        emit_ev    = 1'b0;
        emit_last  = 1'b0;
        emit_rec   = '0;
        mk         = 1'b0;
        mod        = rd_data;
        age1       = rd_data.age;

        issue = (r_state == S_ADV || r_state == S_LOOK || r_state == S_CNT ||
                 r_state == S_DUMP || r_state == S_TICK) && (r_ridx != LAST_IDX);
        scan_done = (r_ridx == LAST_IDX) && !r_evalid;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_nbmode   = (i_action == ACT_NBREQ);
                    n_look     = (i_action == ACT_LOOKUP);
                    n_loc      = i_local_addr;
                    n_nb       = i_neighbor_addr;
                    n_dest     = (i_action == ACT_NBREQ) ? i_neighbor_addr : i_dest_addr;
                    n_cost     = (i_action == ACT_NBREQ) ? 5'd0 : i_adv_cost;
                    n_hit      = 1'b0;
                    n_fresh_ok = 1'b0;
                    n_drop     = 1'b0;
                    n_cnt      = '0;
                    n_nrec     = '0;
                    n_hold_v   = 1'b0;
                    n_ridx     = '0;
                    case (i_action)
                        ACT_ADVERT: n_state = S_ADV;
                        ACT_NBREQ:  n_state = S_ADV;
                        ACT_LOOKUP: n_state = S_LOOK;
                        ACT_DUMP:   n_state = S_CNT;
                        ACT_TICK:   n_state = S_TICK;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_ADV: begin
                if (r_evalid) begin
                    if (used_e && rd_data.dest == r_dest) begin
                        if (rd_data.loc == r_loc && rd_data.nhop == r_nb) begin
                            if (inc == {1'b0, rd_data.cost}) begin
                                mod.age = 8'd0;
                            end else if (r_cost >= COST_UNREACH) begin
                                mod.cost = r_cost;
                                mk       = 1'b1;
                            end
                        end
                        if (inc < {1'b0, mod.cost}) begin
                            mod.loc  = r_loc;
                            mod.nhop = r_nb;
                            mod.cost = inc[4:0];
                            mod.age  = 8'd0;
                            mk       = 1'b1;
                        end
                        if (mk) begin
                            mod.changed = 1'b1;
                            n_pend      = 1'b1;
                        end
                        wr_en   = 1'b1;
                        wr_data = mod;
                        stop    = 1'b1;
                        n_hit   = 1'b1;
                        n_state = S_ADV_END;
                    end else if (!used_e && !r_fresh_ok) begin
                        n_fresh    = r_eidx;
                        n_fresh_ok = 1'b1;
                    end
                end else if (scan_done) begin
                    n_state = S_ADV_END;
                end
            end
            S_ADV_END: begin
                if (!r_hit) begin
                    if (r_fresh_ok) begin
                        wr_en           = 1'b1;
                        wr_addr         = r_fresh;
                        wr_data.dest    = r_dest;
                        wr_data.loc     = r_loc;
                        wr_data.nhop    = r_nb;
                        wr_data.cost    = (r_cost == COST_LOCAL) ? 5'd0 : inc[4:0];
                        wr_data.age     = 8'd0;
                        wr_data.changed = 1'b1;
                        n_used[r_fresh] = 1'b1;
                        n_pend          = 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                end
                n_ridx  = '0;
                n_state = r_nbmode ? S_DUMP : S_DONE;
            end
            S_LOOK: begin
                if (r_evalid && used_e && rd_data.dest == r_dest) begin
                    n_hold   = rd_data;
                    n_hold_v = 1'b1;
                    stop     = 1'b1;
                    n_state  = S_DONE;
                end else if (scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_CNT: begin
                if (r_evalid && used_e && rd_data.changed) begin
                    n_cnt = r_cnt + IW'(1);
                end else if (scan_done) begin
                    n_pend  = (int'(r_cnt) > MAX_OUT);
                    n_ridx  = '0;
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (r_evalid && used_e && r_nrec != RECW'(MAX_OUT) &&
                    (r_nbmode ? (rd_data.nhop != r_nb) : rd_data.changed)) begin
                    emit     = r_hold_v;
                    emit_ev  = 1'b1;
                    emit_rec = r_hold;
                    n_hold   = rd_data;
                    n_hold_v = 1'b1;
                    n_nrec   = r_nrec + RECW'(1);
                    if (!r_nbmode) begin
                        wr_en           = 1'b1;
                        wr_data.changed = 1'b0;
                    end
                end else if (scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_TICK: begin
                if (r_evalid && used_e) begin
                    if (rd_data.cost == 5'd0) begin
                        age1 = 8'd0;
                    end else if (rd_data.age != AGE_MAX) begin
                        age1 = rd_data.age + 8'd1;
                    end
                    mod.age = age1;
                    if (age1 >= r_inv && rd_data.cost != COST_UNREACH) begin
                        mod.cost    = COST_UNREACH;
                        mod.changed = 1'b1;
                        n_pend      = 1'b1;
                    end else if (age1 >= r_flush) begin
                        n_used[r_eidx] = 1'b0;
                    end
                    wr_en   = 1'b1;
                    wr_data = mod;
                end else if (scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (r_hold_v) begin
                    emit_ev  = 1'b1;
                    emit_rec = r_hold;
                end else if (r_look) begin
                    emit_rec.dest = r_dest;
                    emit_rec.cost = COST_UNREACH;
                    emit_rec.loc  = r_own;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_evalid = issue && !stop;
        if (issue) begin
            n_ridx = r_ridx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ridx    <= '0;
            r_evalid  <= 1'b0;
            r_used    <= '0;
            r_pend    <= 1'b0;
            r_hold_v  <= 1'b0;
            r_o_valid <= 1'b0;
            r_own     <= RST_OWN_ADDR;
            r_inv     <= RST_INVALID;
            r_flush   <= RST_FLUSH;
        end else begin
            r_state   <= n_state;
            r_ridx    <= n_ridx;
            r_evalid  <= n_evalid;
            r_used    <= n_used;
            r_pend    <= n_pend;
            r_hold_v  <= n_hold_v;
            r_o_valid <= emit;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OWN_ADDR: r_own   <= i_cfg_data;
                    CFG_INVALID:  r_inv   <= i_cfg_data;
                    CFG_FLUSH:    r_flush <= i_cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx     <= r_ridx[AW-1:0];
        r_nbmode   <= n_nbmode;
        r_look     <= n_look;
        r_loc      <= n_loc;
        r_nb       <= n_nb;
        r_dest     <= n_dest;
        r_cost     <= n_cost;
        r_hit      <= n_hit;
        r_fresh    <= n_fresh;
        r_fresh_ok <= n_fresh_ok;
        r_drop     <= n_drop;
        r_cnt      <= n_cnt;
        r_nrec     <= n_nrec;
        r_hold     <= n_hold;
        if (emit) begin
            r_o_ev     <= emit_ev;
            r_o_dest   <= emit_rec.dest;
            r_o_cost   <= emit_rec.cost;
            r_o_loc    <= emit_rec.loc;
            r_o_next   <= emit_rec.nhop;
            r_o_status <= r_drop;
            r_o_pend   <= r_pend;
            r_o_last   <= emit_last;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_result_valid    = r_o_valid;
    assign o_entry_valid     = r_o_ev;
    assign o_route_dest      = r_o_dest;
    assign o_route_cost      = r_o_cost;
    assign o_route_local     = r_o_loc;
    assign o_route_next      = r_o_next;
    assign o_status          = r_o_status;
    assign o_changes_pending = r_o_pend;
    assign o_last            = r_o_last;

endmodule

// ----- src/dvrt_checker.sv -----
// Port-level checker for the distance-vector route table, bound to the top level.
// Depends only on the top level's ports.
module dvrt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_result_valid,
    input logic       o_entry_valid,
    input logic       o_last
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("Accepted transfer did not make the block busy.");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |-> busy)
        else $error("Non-final result shown while the block is idle.");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_entry_valid |-> o_last)
        else $error("Result without a record is not the final result.");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid && o_last)
        else $error("Block went idle without its final result.");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);
